@@ hdl/gas_climate_window_alarm_defines.svh @@
// Assertion macros for the gas and climate window alarm checker.
// Depends on nothing; included by the checker file.
`ifndef GAS_CLIMATE_WINDOW_ALARM_DEFINES_SVH
`define GAS_CLIMATE_WINDOW_ALARM_DEFINES_SVH

// Check a property while out of reset.
`define GCWA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property at every edge, reset included.
`define GCWA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ hdl/gcwa_pkg.sv @@
// Shared types, constants and helpers of the gas and climate window alarm.
// Depends on nothing.
package gcwa_pkg;

  // Default parameter values
  localparam int WINDOW_LEN_DEF   = 5;
  localparam int WARMUP_COUNT_DEF = 5;
  localparam int COUNT_WRAP_DEF   = 1000;

  localparam int COUNT_W       = 10;
  localparam int COUNT_RESTART = 5;

  // Stream payload widths
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 15;

  // Channel value widths held in the windows (signed)
  localparam int TEMP_W  = 8;
  localparam int HUMID_W = 8;
  localparam int CO_W    = 14;
  localparam int CO2_W   = 13;

  // CO2: raw * 2500 / 27980 as one multiply by a scaled reciprocal
  localparam logic [29:0] CO2_MULT  = 30'd767506750;
  localparam int          CO2_SHIFT = 33;

  // CO conversion
  localparam logic [15:0] CO_OFFSET = 16'd620;
  localparam logic [15:0] CO_BASE   = 16'd17000;
  localparam logic [22:0] CO_MULT   = 23'd4534390;  // 10 * ceil(2^24 / 37)
  localparam int          CO_SHIFT  = 24;
  localparam logic [13:0] CO_KNEE   = 14'd41;
  localparam logic signed [13:0] CO_BIAS_HI = 14'sd41;
  localparam logic signed [13:0] CO_BIAS_LO = 14'sd40;

  // Divide by ten for inputs up to 1024
  localparam logic [10:0] DIV10_MULT  = 11'd1639;
  localparam int          DIV10_SHIFT = 14;

  // Window average divider
  localparam int AVG_MAG_W   = 18;
  localparam int AVG_RECIP_W = 22;
  localparam int AVG_SHIFT   = 22;

  // Register reset values
  localparam logic signed [7:0] TEMP_HIGH_RST  = 8'sd28;
  localparam logic signed [7:0] TEMP_LOW_RST   = 8'sd10;
  localparam logic [6:0]        HUMID_HIGH_RST = 7'd70;
  localparam logic [6:0]        HUMID_LOW_RST  = 7'd10;
  localparam logic [14:0]       CO_LIMIT_RST   = 15'd200;
  localparam logic [14:0]       CO2_LIMIT_RST  = 15'd12500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_HIGH  = 3'd0,
    REG_TEMP_LOW   = 3'd1,
    REG_HUMID_HIGH = 3'd2,
    REG_HUMID_LOW  = 3'd3,
    REG_CO_LIMIT   = 3'd4,
    REG_CO2_LIMIT  = 3'd5
  } cfg_idx_e;

  // Converted sample set, one value per window
  typedef struct packed {
    logic signed [TEMP_W-1:0]  temp;
    logic signed [HUMID_W-1:0] humid;
    logic signed [CO_W-1:0]    co;
    logic signed [CO2_W-1:0]   co2;
  } conv_t;

  // Quotient of a window magnitude by the window length, given its reciprocal
  function automatic logic [AVG_MAG_W-1:0] avg_div(input logic [AVG_MAG_W-1:0] mag,
                                                    input logic [AVG_RECIP_W-1:0] recip);
    logic [AVG_MAG_W+AVG_RECIP_W-1:0] prod;
    prod = (AVG_MAG_W + AVG_RECIP_W)'(mag) * (AVG_MAG_W + AVG_RECIP_W)'(recip);
    return prod[AVG_SHIFT+AVG_MAG_W-1:AVG_SHIFT];
  endfunction

endpackage

@@ hdl/gcwa_convert.sv @@
// Sample conversion: raw gas codes to ppm, tenths to whole units.
// Depends on gcwa_pkg.
module gcwa_convert import gcwa_pkg::*; (
  input  logic [14:0]        co2_raw_i,
  input  logic [14:0]        co_raw_i,
  input  logic signed [10:0] temp_tenths_i,
  input  logic [9:0]         humid_tenths_i,
  output conv_t              conv_o
);

  logic [44:0] co2_prod;
  logic [15:0] co_v;
  logic [15:0] co_diff;
  logic [37:0] co_prod;
  logic [13:0] co_x;
  logic        t_neg;
  logic [10:0] t_mag;
  logic [24:0] t_prod;
  logic [6:0]  t_q;
  logic [23:0] h_prod;

  always_comb begin
    co2_prod = 45'(co2_raw_i) * 45'(CO2_MULT);
    conv_o.co2 = {1'b0, co2_prod[CO2_SHIFT+11:CO2_SHIFT]};

    co_v    = 16'(co_raw_i) + CO_OFFSET;
    co_diff = co_v - CO_BASE;
    co_prod = 38'(co_diff[14:0]) * 38'(CO_MULT);
    co_x    = co_prod[CO_SHIFT+13:CO_SHIFT];
    if (co_v < CO_BASE) begin
      conv_o.co = '0;
    end else if (co_x >= CO_KNEE) begin
      conv_o.co = $signed(co_x) - CO_BIAS_HI;
    end else begin
      conv_o.co = $signed(co_x) - CO_BIAS_LO;
    end

    // truncate toward zero: divide the magnitude, restore the sign
    t_neg  = temp_tenths_i[10];
    t_mag  = t_neg ? 11'(-temp_tenths_i) : 11'(temp_tenths_i);
    t_prod = 25'(t_mag) * 25'(DIV10_MULT);
    t_q    = t_prod[DIV10_SHIFT+6:DIV10_SHIFT];
    conv_o.temp = t_neg ? -$signed({1'b0, t_q}) : $signed({1'b0, t_q});

    h_prod = 24'(humid_tenths_i) * 24'(DIV10_MULT);
    conv_o.humid = {1'b0, h_prod[DIV10_SHIFT+6:DIV10_SHIFT]};
  end

endmodule

@@ hdl/gcwa_window.sv @@
// Sliding window of one channel with a running sum register.
// Depends on nothing; instantiated once per channel by the top level.
module gcwa_window #(
  parameter  int W    = 8,
  parameter  int LEN  = 5,
  localparam int SumW = W + $clog2(LEN)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic signed [W-1:0]    value_i,
  output logic signed [SumW-1:0] sum_o
);

  logic signed [W-1:0]    tap_q [LEN];
  logic signed [SumW-1:0] sum_q;
  logic signed [SumW-1:0] sum_d;

  // drop the oldest tap, add the new value
  assign sum_d = sum_q - SumW'(tap_q[0]) + SumW'(value_i);
  assign sum_o = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEN; i++) begin
        tap_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (push_i) begin
      for (int i = 0; i < LEN - 1; i++) begin
        tap_q[i] <= tap_q[i+1];
      end
      tap_q[LEN-1] <= value_i;
      sum_q <= sum_d;
    end
  end

endmodule

@@ hdl/gas_climate_window_alarm.sv @@
// Gas and climate window alarm: top level with pipeline control and registers.
// Depends on gcwa_pkg, gcwa_convert and gcwa_window.
//
// Usage: the slave stream carries one sample set per transfer (CO2 and CO
// converter codes, temperature and humidity in tenths). The master stream
// returns one result per transfer: the four window averages and four alarm
// flags. Configuration limits are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i while no item is in flight; unknown indexes are ignored.
// A result passes the input register, the conversion and window update, then
// the divide and compare into the output register. Throughput: one item per
// cycle while the receiver takes results, set by the three-stage register
// pipeline with one constant multiply per channel in conversion and in divide.
// Reset clears the windows, the warmup counter, the stage valids and loads
// the default limits. When the receiver stalls, the result holds in the
// output register and the two stages behind it keep filling; tready drops
// only once all three stages are occupied.
module gas_climate_window_alarm import gcwa_pkg::*; #(
  parameter int WINDOW_LEN   = WINDOW_LEN_DEF,
  parameter int WARMUP_COUNT = WARMUP_COUNT_DEF,
  parameter int COUNT_WRAP   = COUNT_WRAP_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // co2_raw[14:0], co_raw[29:15], temp_tenths[40:30], humid_tenths[50:41], zero fill
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // temp_avg[7:0], humid_avg[14:8], co_avg[27:15], co2_avg[39:28], temp_alarm[40],
  // humid_alarm[41], co_alarm[42], co2_alarm[43], zero fill
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int LenW   = $clog2(WINDOW_LEN);
  localparam int TSumW  = TEMP_W + LenW;
  localparam int HSumW  = HUMID_W + LenW;
  localparam int CoSumW = CO_W + LenW;
  localparam int C2SumW = CO2_W + LenW;
  localparam logic [AVG_RECIP_W-1:0] AvgRecip =
    AVG_RECIP_W'(((64'd1 << AVG_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

  // Stage A: input register
  logic               va_q;
  logic [14:0]        co2_raw_q;
  logic [14:0]        co_raw_q;
  logic signed [10:0] temp_tenths_q;
  logic [9:0]         humid_tenths_q;

  // Stage B: window sums live in the window modules
  logic vb_q;
  logic warm_q;
  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W:0]   count_inc;
  logic [COUNT_W-1:0] count_d;

  // Output register
  logic                 vo_q;
  logic [M_TDATA_W-1:0] out_q;
  logic [M_TDATA_W-1:0] out_d;

  // Limits
  logic signed [7:0] temp_high_q;
  logic signed [7:0] temp_low_q;
  logic [6:0]        humid_high_q;
  logic [6:0]        humid_low_q;
  logic [14:0]       co_limit_q;
  logic [14:0]       co2_limit_q;

  logic  adv_a;
  logic  adv_b;
  conv_t conv;

  logic signed [TSumW-1:0]  temp_sum;
  logic signed [HSumW-1:0]  humid_sum;
  logic signed [CoSumW-1:0] co_sum;
  logic signed [C2SumW-1:0] co2_sum;

  logic                 t_neg;
  logic [TSumW-1:0]     t_mag;
  logic [AVG_MAG_W-1:0] t_q;
  logic [AVG_MAG_W-1:0] h_q;
  logic [AVG_MAG_W-1:0] co_q;
  logic [AVG_MAG_W-1:0] co2_q;
  logic signed [7:0]    temp_avg;
  logic [6:0]           humid_avg;
  logic [12:0]          co_avg;
  logic [11:0]          co2_avg;
  logic                 temp_alarm;
  logic                 humid_alarm;
  logic                 co_alarm;
  logic                 co2_alarm;

  assign adv_b = vb_q && (!vo_q || m_axis_tready);
  assign adv_a = va_q && (!vb_q || adv_b);
  assign s_axis_tready = !va_q || adv_a;
  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = out_q;

  gcwa_convert u_convert (
    .co2_raw_i      (co2_raw_q),
    .co_raw_i       (co_raw_q),
    .temp_tenths_i  (temp_tenths_q),
    .humid_tenths_i (humid_tenths_q),
    .conv_o         (conv)
  );

  gcwa_window #(.W(TEMP_W), .LEN(WINDOW_LEN)) u_temp_win (
    .clk_i, .rst_ni, .push_i(adv_a), .value_i(conv.temp), .sum_o(temp_sum)
  );
  gcwa_window #(.W(HUMID_W), .LEN(WINDOW_LEN)) u_humid_win (
    .clk_i, .rst_ni, .push_i(adv_a), .value_i(conv.humid), .sum_o(humid_sum)
  );
  gcwa_window #(.W(CO_W), .LEN(WINDOW_LEN)) u_co_win (
    .clk_i, .rst_ni, .push_i(adv_a), .value_i(conv.co), .sum_o(co_sum)
  );
  gcwa_window #(.W(CO2_W), .LEN(WINDOW_LEN)) u_co2_win (
    .clk_i, .rst_ni, .push_i(adv_a), .value_i(conv.co2), .sum_o(co2_sum)
  );

  // Warmup counter wraps back to its restart value past the limit
  always_comb begin
    count_inc = (COUNT_W + 1)'(count_q) + (COUNT_W + 1)'(1);
    if (count_inc > (COUNT_W + 1)'(COUNT_WRAP)) begin
      count_d = COUNT_W'(COUNT_RESTART);
    end else begin
      count_d = count_inc[COUNT_W-1:0];
    end
  end

  // Averages truncate toward zero; a negative CO window clamps to zero
  always_comb begin
    t_neg    = temp_sum[TSumW-1];
    t_mag    = t_neg ? TSumW'(-temp_sum) : TSumW'(temp_sum);
    t_q      = avg_div(AVG_MAG_W'(t_mag), AvgRecip);
    temp_avg = t_neg ? -$signed(t_q[7:0]) : $signed(t_q[7:0]);

    h_q       = avg_div(AVG_MAG_W'(HSumW'(humid_sum)), AvgRecip);
    humid_avg = h_q[6:0];

    co_q   = avg_div(AVG_MAG_W'(CoSumW'(co_sum)), AvgRecip);
    co_avg = co_sum[CoSumW-1] ? '0 : co_q[12:0];

    co2_q   = avg_div(AVG_MAG_W'(C2SumW'(co2_sum)), AvgRecip);
    co2_avg = co2_q[11:0];

    temp_alarm  = warm_q && (temp_avg > temp_high_q || temp_avg < temp_low_q);
    humid_alarm = warm_q && (humid_avg > humid_high_q || humid_avg < humid_low_q);
    co_alarm    = warm_q && (15'(co_avg) > co_limit_q);
    co2_alarm   = warm_q && (15'(co2_avg) > co2_limit_q);

    out_d = {4'b0000, co2_alarm, co_alarm, humid_alarm, temp_alarm,
             co2_avg, co_avg, humid_avg, temp_avg};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      vo_q    <= 1'b0;
      count_q <= '0;
    end else begin
      if (s_axis_tready) begin
        va_q <= s_axis_tvalid;
      end
      if (!vb_q || adv_b) begin
        vb_q <= va_q;
      end
      if (!vo_q || m_axis_tready) begin
        vo_q <= vb_q;
      end
      if (adv_a) begin
        count_q <= count_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      co2_raw_q      <= s_axis_tdata[14:0];
      co_raw_q       <= s_axis_tdata[29:15];
      temp_tenths_q  <= $signed(s_axis_tdata[40:30]);
      humid_tenths_q <= s_axis_tdata[50:41];
    end
    if (adv_a) begin
      warm_q <= count_q > COUNT_W'(WARMUP_COUNT);
    end
    if (adv_b) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_high_q  <= TEMP_HIGH_RST;
      temp_low_q   <= TEMP_LOW_RST;
      humid_high_q <= HUMID_HIGH_RST;
      humid_low_q  <= HUMID_LOW_RST;
      co_limit_q   <= CO_LIMIT_RST;
      co2_limit_q  <= CO2_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_TEMP_HIGH:  temp_high_q  <= $signed(cfg_wdata_i[7:0]);
        REG_TEMP_LOW:   temp_low_q   <= $signed(cfg_wdata_i[7:0]);
        REG_HUMID_HIGH: humid_high_q <= cfg_wdata_i[6:0];
        REG_HUMID_LOW:  humid_low_q  <= cfg_wdata_i[6:0];
        REG_CO_LIMIT:   co_limit_q   <= cfg_wdata_i;
        REG_CO2_LIMIT:  co2_limit_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/gcwa_checker.sv @@
// Port-level checker for the gas and climate window alarm, with its bind.
// Depends on gcwa_pkg and the assertion macros header.
`include "gas_climate_window_alarm_defines.svh"

module gcwa_checker import gcwa_pkg::*; #(
  parameter int WARMUP_COUNT = WARMUP_COUNT_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready
);

  // Count delivered results, saturating at 255
  logic [7:0] out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready && out_cnt_q != 8'hFF) begin
      out_cnt_q <= out_cnt_q + 8'd1;
    end
  end

  `GCWA_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "stalled result changed")

  `GCWA_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid,
    "result valid during reset")

  `GCWA_ASSERT(a_backpressure, clk_i, rst_ni,
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready,
    "input stalled while output side is free")

  `GCWA_ASSERT(a_warmup_quiet, clk_i, rst_ni,
    m_axis_tvalid && (out_cnt_q <= 8'(WARMUP_COUNT)) |-> m_axis_tdata[43:40] == 4'b0000,
    "alarm raised during warmup")

endmodule

bind gas_climate_window_alarm gcwa_checker #(.WARMUP_COUNT(WARMUP_COUNT)) u_gcwa_checker (.*);
